@@ design/bpse_pkg.sv @@
package bpse_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int CW         = 16;
    localparam int TW         = 17;
    localparam int D2W        = 2 * CW + 1;

    localparam logic [TW-1:0] T_ONE        = 17'h10000;
    localparam logic [CW-1:0] RADIUS_RESET = 16'd3277;

    localparam logic [2:0] ACT_APPEND    = 3'd0;
    localparam logic [2:0] ACT_REM_FIRST = 3'd1;
    localparam logic [2:0] ACT_REM_LAST  = 3'd2;
    localparam logic [2:0] ACT_MOVE      = 3'd3;
    localparam logic [2:0] ACT_NEAREST   = 3'd4;
    localparam logic [2:0] ACT_EVAL      = 3'd5;

    typedef struct packed {
        logic st_shift;
        logic wk_load;
        logic wk_shift;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_NEAR  = 4'b0010,
        S_EVAL  = 4'b0100,
        S_EDONE = 4'b1000
    } t_state;

endpackage

@@ design/bezier_point_store_evaluator.sv @@
// Bezier control-point store and evaluator. Append, remove, move and out-of-range
// commands, and evaluations of fewer than two points, are answered from the
// result register in the cycle after they are accepted. A nearest search rotates
// the ring of point cells once. Evaluation over n points runs n-1 de Casteljau
// passes through one shared lerp unit per axis, each pass a full rotation of the work ring.
// The input is taken while the controller is idle and the result register is free.
module bezier_point_store_evaluator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_coord_x,
    input  logic [15:0] i_coord_y,
    input  logic [5:0]  i_point_index,
    input  logic [16:0] i_param_t,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_curve_x,
    output logic [15:0] o_curve_y,
    output logic        o_hit,
    output logic [5:0]  o_hit_index,
    output logic [6:0]  o_point_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    localparam int M   = bpse_pkg::MAX_POINTS;
    localparam int IW  = bpse_pkg::IDX_W;
    localparam int NW  = bpse_pkg::CNT_W;
    localparam int CW  = bpse_pkg::CW;
    localparam int D2W = bpse_pkg::D2W;

    bpse_pkg::t_state r_state, n_state;
    logic [NW-1:0]  r_cnt, n_cnt;
    logic [NW-1:0]  r_pass, n_pass, r_m, n_m;
    logic [IW-1:0]  r_s, n_s;
    logic [CW-1:0]  r_radius;
    logic [2*CW-1:0] r_r2;
    logic [CW-1:0]  r_qx, r_qy;
    logic [bpse_pkg::TW-1:0] r_t;
    logic           r_found, n_found;
    logic [D2W-1:0] r_best, n_best;
    logic [IW-1:0]  r_bidx, n_bidx;
    logic           r_ovalid, n_ovalid;
    logic [CW-1:0]  r_ox, n_ox, r_oy, n_oy;
    logic           r_ohit, n_ohit;
    logic [IW-1:0]  r_oidx, n_oidx;
    logic [NW-1:0]  r_ocnt, n_ocnt;

    bpse_pkg::t_cell_ctl ctl;
    logic            wr_en;
    logic [IW-1:0]   wr_idx;
    logic [CW-1:0]   sx [M], sy [M], wx [M], wy [M];
    logic [CW-1:0]   feed_x, feed_y, lx, ly;
    logic            accept, out_free;
    logic [bpse_pkg::TW-1:0] t_sat;
    logic [CW-1:0]   dx, dy;
    logic [D2W-1:0]  d2;
    logic            last_step;

    assign out_free = !r_ovalid || i_ready;
    assign o_ready  = (r_state == bpse_pkg::S_IDLE) && out_free;
    assign accept   = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;
    assign t_sat = (i_param_t > bpse_pkg::T_ONE) ? bpse_pkg::T_ONE : i_param_t;
    assign last_step = (r_s == IW'(M - 1));

    bpse_lerp u_lerp_x (.i_a(wx[0]), .i_b(wx[1]), .i_t(r_t), .o_y(lx));
    bpse_lerp u_lerp_y (.i_a(wy[0]), .i_b(wy[1]), .i_t(r_t), .o_y(ly));

    always_comb begin
        dx = (r_qx >= sx[0]) ? r_qx - sx[0] : sx[0] - r_qx;
        dy = (r_qy >= sy[0]) ? r_qy - sy[0] : sy[0] - r_qy;
        d2 = D2W'(dx * dx) + D2W'(dy * dy);
        feed_x = ({1'b0, r_s} < r_m) ? lx : wx[0];
        feed_y = ({1'b0, r_s} < r_m) ? ly : wy[0];
    end

    genvar k;
    generate
        for (k = 0; k < M; k++) begin : g_cell
            bpse_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_wr    (wr_en && (wr_idx == IW'(k))),
                .i_wr_x  (i_coord_x),
                .i_wr_y  (i_coord_y),
                .i_nb_sx (sx[(k + 1) % M]),
                .i_nb_sy (sy[(k + 1) % M]),
                .i_nb_wx ((k == M - 1) ? feed_x : wx[(k + 1) % M]),
                .i_nb_wy ((k == M - 1) ? feed_y : wy[(k + 1) % M]),
                .o_sx    (sx[k]),
                .o_sy    (sy[k]),
                .o_wx    (wx[k]),
                .o_wy    (wy[k])
            );
        end
    endgenerate

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_pass   = r_pass;
        n_m      = r_m;
        n_s      = r_s;
        n_found  = r_found;
        n_best   = r_best;
        n_bidx   = r_bidx;
        n_ovalid = r_ovalid && !i_ready;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_ohit   = r_ohit;
        n_oidx   = r_oidx;
        n_ocnt   = r_ocnt;
        ctl      = '0;
        wr_en    = 1'b0;
        wr_idx   = '0;
        case (r_state)
            bpse_pkg::S_IDLE: begin
                if (accept) begin
                    n_ox   = '0;
                    n_oy   = '0;
                    n_ohit = 1'b0;
                    n_oidx = '0;
                    n_s    = '0;
                    case (i_action)
                        bpse_pkg::ACT_APPEND: begin
                            wr_en = 1'b1;
                            if (r_cnt == NW'(M)) begin
                                ctl.st_shift = 1'b1;
                                wr_idx = IW'(M - 1);
                            end else begin
                                wr_idx = r_cnt[IW-1:0];
                                n_cnt  = r_cnt + NW'(1);
                            end
                        end
                        bpse_pkg::ACT_REM_FIRST: begin
                            if (r_cnt != '0) begin
                                ctl.st_shift = 1'b1;
                                n_cnt = r_cnt - NW'(1);
                            end
                        end
                        bpse_pkg::ACT_REM_LAST: begin
                            if (r_cnt != '0) n_cnt = r_cnt - NW'(1);
                        end
                        bpse_pkg::ACT_MOVE: begin
                            wr_idx = i_point_index[IW-1:0];
                            wr_en  = ({1'b0, i_point_index} < 7'(r_cnt));
                        end
                        bpse_pkg::ACT_NEAREST: begin
                            n_found = 1'b0;
                            n_state = bpse_pkg::S_NEAR;
                        end
                        bpse_pkg::ACT_EVAL: begin
                            if (r_cnt == NW'(1)) begin
                                n_ox = sx[0];
                                n_oy = sy[0];
                            end else if (r_cnt != '0) begin
                                ctl.wk_load = 1'b1;
                                n_pass  = r_cnt - NW'(1);
                                n_m     = r_cnt - NW'(1);
                                n_state = bpse_pkg::S_EVAL;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_ocnt = n_cnt;
                    if (n_state == bpse_pkg::S_IDLE) n_ovalid = 1'b1;
                end
            end
            bpse_pkg::S_NEAR: begin
                ctl.st_shift = 1'b1;
                if (({1'b0, r_s} < r_cnt) && (d2 <= D2W'(r_r2))
                    && (!r_found || d2 <= r_best)) begin
                    n_found = 1'b1;
                    n_best  = d2;
                    n_bidx  = r_s;
                end
                n_s = r_s + IW'(1);
                if (last_step) begin
                    n_ohit   = n_found;
                    n_oidx   = n_found ? n_bidx : '0;
                    n_ovalid = 1'b1;
                    n_state  = bpse_pkg::S_IDLE;
                end
            end
            bpse_pkg::S_EVAL: begin
                ctl.wk_shift = 1'b1;
                n_s = r_s + IW'(1);
                if (last_step) begin
                    n_pass = r_pass - NW'(1);
                    n_m    = r_m - NW'(1);
                    if (r_pass == NW'(1)) n_state = bpse_pkg::S_EDONE;
                end
            end
            bpse_pkg::S_EDONE: begin
                n_ox     = wx[0];
                n_oy     = wy[0];
                n_ovalid = 1'b1;
                n_state  = bpse_pkg::S_IDLE;
            end
            default: begin
                n_state = bpse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bpse_pkg::S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_radius <= bpse_pkg::RADIUS_RESET;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
            if (i_cfg_valid) r_radius <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r2    <= r_radius * r_radius;
        r_pass  <= n_pass;
        r_m     <= n_m;
        r_s     <= n_s;
        r_found <= n_found;
        r_best  <= n_best;
        r_bidx  <= n_bidx;
        r_ox    <= n_ox;
        r_oy    <= n_oy;
        r_ohit  <= n_ohit;
        r_oidx  <= n_oidx;
        r_ocnt  <= n_ocnt;
        if (accept) begin
            r_qx <= i_coord_x;
            r_qy <= i_coord_y;
            r_t  <= t_sat;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_curve_x     = r_ox;
    assign o_curve_y     = r_oy;
    assign o_hit         = r_ohit;
    assign o_hit_index   = r_oidx;
    assign o_point_count = r_ocnt;

endmodule

@@ design/bpse_cell.sv @@
module bpse_cell (
    input  logic                    i_clk,
    input  bpse_pkg::t_cell_ctl     i_ctl,
    input  logic                    i_wr,
    input  logic [bpse_pkg::CW-1:0] i_wr_x,
    input  logic [bpse_pkg::CW-1:0] i_wr_y,
    input  logic [bpse_pkg::CW-1:0] i_nb_sx,
    input  logic [bpse_pkg::CW-1:0] i_nb_sy,
    input  logic [bpse_pkg::CW-1:0] i_nb_wx,
    input  logic [bpse_pkg::CW-1:0] i_nb_wy,
    output logic [bpse_pkg::CW-1:0] o_sx,
    output logic [bpse_pkg::CW-1:0] o_sy,
    output logic [bpse_pkg::CW-1:0] o_wx,
    output logic [bpse_pkg::CW-1:0] o_wy
);

    logic [bpse_pkg::CW-1:0] r_sx, r_sy, r_wx, r_wy;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_sx <= i_wr_x;
            r_sy <= i_wr_y;
        end else if (i_ctl.st_shift) begin
            r_sx <= i_nb_sx;
            r_sy <= i_nb_sy;
        end
        if (i_ctl.wk_load) begin
            r_wx <= r_sx;
            r_wy <= r_sy;
        end else if (i_ctl.wk_shift) begin
            r_wx <= i_nb_wx;
            r_wy <= i_nb_wy;
        end
    end

    assign o_sx = r_sx;
    assign o_sy = r_sy;
    assign o_wx = r_wx;
    assign o_wy = r_wy;

endmodule

@@ design/bpse_lerp.sv @@
module bpse_lerp (
    input  logic [bpse_pkg::CW-1:0] i_a,
    input  logic [bpse_pkg::CW-1:0] i_b,
    input  logic [bpse_pkg::TW-1:0] i_t,
    output logic [bpse_pkg::CW-1:0] o_y
);

    logic [bpse_pkg::TW-1:0]        t_inv;
    logic [bpse_pkg::TW+bpse_pkg::CW:0] sum;

    always_comb begin
        t_inv = bpse_pkg::T_ONE - i_t;
        sum = ({1'b0, t_inv} * {{(bpse_pkg::TW-bpse_pkg::CW){1'b0}}, i_a})
            + ({1'b0, i_t} * {{(bpse_pkg::TW-bpse_pkg::CW){1'b0}}, i_b})
            + (bpse_pkg::TW+bpse_pkg::CW+1)'(32768);
        o_y = sum[bpse_pkg::CW+15:16];
    end

endmodule

@@ design/bpse_checker.sv @@
module bpse_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_hit,
    input logic [5:0] o_hit_index,
    input logic [6:0] o_point_count,
    input logic       o_ready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid) else $error("result dropped");

    a_hit_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_hit_index == 6'd0) else $error("index without hit");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_point_count <= 7'd64) else $error("count overflow");

    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |-> !o_ready) else $error("item taken while result waits");

endmodule

bind bezier_point_store_evaluator bpse_checker u_bpse_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_hit         (o_hit),
    .o_hit_index   (o_hit_index),
    .o_point_count (o_point_count),
    .o_ready       (o_ready)
);

@@ tb/sv/bezier_point_store_evaluator_test.sv @@
`timescale 1ns / 1ps

module bezier_point_store_evaluator_test;

    typedef struct {
        logic [2:0]  action;
        logic [15:0] cx;
        logic [15:0] cy;
        logic [5:0]  idx;
        logic [16:0] t;
    } t_cmd;

    typedef struct {
        logic [15:0] rx;
        logic [15:0] ry;
        logic        hit;
        logic [5:0]  hidx;
        logic [6:0]  count;
    } t_curve_result;

    typedef struct {
        t_cmd          cmd;
        bit            typed;
        t_curve_result res;
    } t_dir_row;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_action = '0;
    logic [15:0] i_coord_x = '0;
    logic [15:0] i_coord_y = '0;
    logic [5:0]  i_point_index = '0;
    logic [16:0] i_param_t = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_curve_x;
    logic [15:0] o_curve_y;
    logic        o_hit;
    logic [5:0]  o_hit_index;
    logic [6:0]  o_point_count;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data = '0;

    bezier_point_store_evaluator dut (.*);

    always #1 i_clk = ~i_clk;

    logic [15:0]   pts_x [bpse_pkg::MAX_POINTS];
    logic [15:0]   pts_y [bpse_pkg::MAX_POINTS];
    int            npts;
    logic [15:0]   radius;
    t_curve_result expected_q[$];
    int            mismatches = 0;
    int            results_seen = 0;
    int            hits_seen = 0;
    int            idle_cycles = 0;
    bit            done = 0;
    int            stall_mode = 0;

    function automatic logic [15:0] lerp16(logic [15:0] a, logic [15:0] b, logic [16:0] t);
        logic [47:0] s;
        s = (48'(bpse_pkg::T_ONE) - t) * a + 48'(t) * b + 48'd32768;
        return s[31:16];
    endfunction

    function automatic t_curve_result apply_cmd(t_cmd c);
        t_curve_result r;
        logic [16:0]   t;
        logic [32:0]   r2, d2, best;
        logic [15:0]   dx, dy;
        logic [15:0]   wx [bpse_pkg::MAX_POINTS];
        logic [15:0]   wy [bpse_pkg::MAX_POINTS];
        r = '{default: '0};
        t = (c.t > bpse_pkg::T_ONE) ? bpse_pkg::T_ONE : c.t;
        case (c.action)
            bpse_pkg::ACT_APPEND: begin
                if (npts == bpse_pkg::MAX_POINTS) begin
                    for (int k = 0; k < bpse_pkg::MAX_POINTS - 1; k++) begin
                        pts_x[k] = pts_x[k + 1];
                        pts_y[k] = pts_y[k + 1];
                    end
                    npts--;
                end
                pts_x[npts] = c.cx;
                pts_y[npts] = c.cy;
                npts++;
            end
            bpse_pkg::ACT_REM_FIRST: begin
                if (npts > 0) begin
                    for (int k = 0; k < npts - 1; k++) begin
                        pts_x[k] = pts_x[k + 1];
                        pts_y[k] = pts_y[k + 1];
                    end
                    npts--;
                end
            end
            bpse_pkg::ACT_REM_LAST: if (npts > 0) npts--;
            bpse_pkg::ACT_MOVE: begin
                if (c.idx < npts) begin
                    pts_x[c.idx] = c.cx;
                    pts_y[c.idx] = c.cy;
                end
            end
            bpse_pkg::ACT_NEAREST: begin
                r2 = 33'(radius) * radius;
                best = '1;
                for (int k = 0; k < npts; k++) begin
                    dx = (c.cx >= pts_x[k]) ? c.cx - pts_x[k] : pts_x[k] - c.cx;
                    dy = (c.cy >= pts_y[k]) ? c.cy - pts_y[k] : pts_y[k] - c.cy;
                    d2 = 33'(dx) * dx + 33'(dy) * dy;
                    if (d2 <= r2 && (!r.hit || d2 <= best)) begin
                        r.hit = 1'b1;
                        best = d2;
                        r.hidx = k[5:0];
                    end
                end
            end
            bpse_pkg::ACT_EVAL: begin
                if (npts > 0) begin
                    for (int k = 0; k < npts; k++) begin
                        wx[k] = pts_x[k];
                        wy[k] = pts_y[k];
                    end
                    for (int i = 1; i < npts; i++)
                        for (int j = 0; j + i < npts; j++) begin
                            wx[j] = lerp16(wx[j], wx[j + 1], t);
                            wy[j] = lerp16(wy[j], wy[j + 1], t);
                        end
                    r.rx = wx[0];
                    r.ry = wy[0];
                end
            end
            default: ;
        endcase
        r.count = 7'(npts);
        return r;
    endfunction

    // receiver
    always @(posedge i_clk) begin
        t_curve_result e;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (o_hit) hits_seen++;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $time);
            end else begin
                e = expected_q.pop_front();
                if (o_curve_x !== e.rx || o_curve_y !== e.ry || o_hit !== e.hit
                    || o_hit_index !== e.hidx || o_point_count !== e.count) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp x=%h y=%h hit=%b idx=%0d n=%0d,",
                            e.rx, e.ry, e.hit, e.hidx, e.count,
                            " got x=%h y=%h hit=%b idx=%0d n=%0d",
                            o_curve_x, o_curve_y, o_hit, o_hit_index, o_point_count);
                end
            end
        end
        case (stall_mode)
            0: i_ready <= 1'b1;
            1: i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
        if (($urandom & 63) == 0) stall_mode <= $urandom_range(0, 2);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !done) begin
            $display("bezier_point_store_evaluator_test: errors");
            $finish;
        end
    end

    task automatic send_cmd(t_cmd c, bit typed, t_curve_result want);
        t_curve_result p;
        i_valid <= 1'b1;
        i_action <= c.action;
        i_coord_x <= c.cx;
        i_coord_y <= c.cy;
        i_point_index <= c.idx;
        i_param_t <= c.t;
        do @(posedge i_clk); while (!o_ready);
        p = apply_cmd(c);
        expected_q.push_back(typed ? want : p);
        if ($urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    task automatic write_radius(logic [15:0] v);
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4100) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        radius = v;
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_cmd mk(logic [2:0] a, logic [15:0] x, logic [15:0] y,
                                logic [5:0] i, logic [16:0] t);
        t_cmd c;
        c = '{a, x, y, i, t};
        return c;
    endfunction

    function automatic t_cmd rand_cmd();
        t_cmd c;
        int   r;
        r = $urandom_range(0, 99);
        c.cx = 16'($urandom);
        c.cy = 16'($urandom);
        c.t = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(0, 65536));
        c.idx = (npts > 0 && r < 80) ? 6'($urandom_range(0, npts - 1)) : 6'($urandom);
        if (r < 35) c.action = bpse_pkg::ACT_APPEND;
        else if (r < 42) c.action = bpse_pkg::ACT_REM_FIRST;
        else if (r < 49) c.action = bpse_pkg::ACT_REM_LAST;
        else if (r < 60) c.action = bpse_pkg::ACT_MOVE;
        else if (r < 80) begin
            c.action = bpse_pkg::ACT_NEAREST;
            if (npts > 0 && $urandom_range(0, 1)) begin
                r = $urandom_range(0, npts - 1);
                c.cx = pts_x[r] + 16'($urandom_range(0, 300)) - 16'd150;
                c.cy = pts_y[r] + 16'($urandom_range(0, 300)) - 16'd150;
            end
        end else if (r < 97) c.action = bpse_pkg::ACT_EVAL;
        else c.action = 3'($urandom_range(6, 7));
        return c;
    endfunction

    t_dir_row      dir_rows[$];
    t_curve_result zr;

    initial begin
        npts = 0;
        radius = bpse_pkg::RADIUS_RESET;
        zr = '{default: '0};
        dir_rows = '{
            '{mk(bpse_pkg::ACT_EVAL, 0, 0, 0, 17'd30000), 1, zr},
            '{mk(bpse_pkg::ACT_REM_FIRST, 0, 0, 0, 0), 1, zr},
            '{mk(bpse_pkg::ACT_REM_LAST, 0, 0, 0, 0), 1, zr},
            '{mk(bpse_pkg::ACT_NEAREST, 16'h1234, 16'h5678, 0, 0), 1, zr},
            '{mk(bpse_pkg::ACT_MOVE, 1, 1, 0, 0), 1, zr},
            '{mk(bpse_pkg::ACT_APPEND, 16'hffff, 16'h0000, 0, 0), 1, '{0, 0, 0, 0, 1}},
            '{mk(bpse_pkg::ACT_EVAL, 0, 0, 0, 17'h1ffff), 1, '{16'hffff, 0, 0, 0, 1}},
            '{mk(bpse_pkg::ACT_APPEND, 16'h0000, 16'hffff, 0, 0), 1, '{0, 0, 0, 0, 2}},
            '{mk(bpse_pkg::ACT_EVAL, 0, 0, 0, 17'd0), 1, '{16'hffff, 0, 0, 0, 2}},
            '{mk(bpse_pkg::ACT_EVAL, 0, 0, 0, bpse_pkg::T_ONE), 1, '{0, 16'hffff, 0, 0, 2}},
            '{mk(bpse_pkg::ACT_EVAL, 0, 0, 0, 17'd32768), 0, zr},
            '{mk(bpse_pkg::ACT_NEAREST, 16'hffff, 16'h0000, 0, 0), 1, '{0, 0, 1, 0, 2}},
            '{mk(bpse_pkg::ACT_APPEND, 16'hffff, 16'h0000, 0, 0), 0, zr},
            '{mk(bpse_pkg::ACT_NEAREST, 16'hffff, 16'h0000, 0, 0), 1, '{0, 0, 1, 2, 3}},
            '{mk(bpse_pkg::ACT_MOVE, 16'h8000, 16'h8000, 6'd63, 0), 1, '{0, 0, 0, 0, 3}},
            '{mk(bpse_pkg::ACT_MOVE, 16'h8000, 16'h8000, 6'd1, 0), 0, zr},
            '{mk(3'd6, 16'hffff, 16'hffff, 6'd63, 17'h1ffff), 1, '{0, 0, 0, 0, 3}},
            '{mk(3'd7, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 3}},
            '{mk(bpse_pkg::ACT_EVAL, 0, 0, 0, 17'd12345), 0, zr},
            '{mk(bpse_pkg::ACT_REM_FIRST, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 2}},
            '{mk(bpse_pkg::ACT_REM_LAST, 0, 0, 0, 0), 1, '{0, 0, 0, 0, 1}}
        };
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (dir_rows[k]) send_cmd(dir_rows[k].cmd, dir_rows[k].typed, dir_rows[k].res);
        // fill past capacity to exercise the full-list drop
        for (int k = 0; k < 70; k++)
            send_cmd(mk(bpse_pkg::ACT_APPEND, 16'($urandom), 16'($urandom), 0, 0), 0, zr);
        send_cmd(mk(bpse_pkg::ACT_EVAL, 0, 0, 0, 17'($urandom_range(0, 65536))), 0, zr);
        send_cmd(mk(bpse_pkg::ACT_NEAREST, pts_x[63], pts_y[63], 0, 0), 0, zr);
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: write_radius(16'd0);
                1: write_radius(16'hffff);
                2: write_radius(16'($urandom_range(200, 4000)));
                default: write_radius(bpse_pkg::RADIUS_RESET);
            endcase
            while (npts > 8) send_cmd(mk(bpse_pkg::ACT_REM_FIRST, 0, 0, 0, 0), 0, zr);
            for (int k = 0; k < 30; k++) begin
                while ($urandom_range(0, 3) == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                end
                send_cmd(rand_cmd(), 0, zr);
            end
        end
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (4100) @(posedge i_clk);
        done = 1;
        $display("covered %0d results (%0d hits), full-list drop, all radius extremes",
                 results_seen, hits_seen);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("bezier_point_store_evaluator_test: clean");
        else
            $display("bezier_point_store_evaluator_test: errors");
        $finish;
    end
endmodule
